// ----- rtl/bscf_pkg.sv -----
// Types and constants shared by the bus servo command framer.
package bscf_pkg;

   localparam int unsigned POS_W     = 16;
   localparam int unsigned ANG_W     = 13;
   localparam int unsigned TIME_W    = 16;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned PROD_W    = POS_W + ANG_W;
   localparam int unsigned NUM_W     = PROD_W + 1;
   localparam int unsigned DIV_BITS  = 2;
   localparam int unsigned DIV_STG   = POS_W / DIV_BITS;
   localparam int unsigned FRAME_MAX = 10;
   localparam int unsigned CNT_W     = $clog2(FRAME_MAX);
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 16;

   localparam logic [BYTE_W-1:0] HDR_BYTE = 8'h55;
   localparam logic [BYTE_W-1:0] CMD_MOVE = 8'h01;
   localparam logic [BYTE_W-1:0] CMD_STOP = 8'h0C;
   localparam logic [BYTE_W-1:0] CMD_LOAD = 8'h1F;
   localparam logic [BYTE_W-1:0] LOAD_ARG = 8'h01;
   localparam logic [BYTE_W-1:0] LEN_MOVE = 8'd7;
   localparam logic [BYTE_W-1:0] LEN_STOP = 8'd3;
   localparam logic [BYTE_W-1:0] LEN_LOAD = 8'd4;

   localparam logic [CNT_W-1:0] LAST_MOVE = 4'd9;
   localparam logic [CNT_W-1:0] LAST_STOP = 4'd5;
   localparam logic [CNT_W-1:0] LAST_LOAD = 4'd6;

   localparam logic [BYTE_W-1:0]       RST_SERVO_ID  = 8'd1;
   localparam logic [POS_W-1:0]        RST_POS_MIN   = 16'd0;
   localparam logic [POS_W-1:0]        RST_POS_MAX   = 16'd1000;
   localparam logic signed [ANG_W-1:0] RST_ANGLE_MIN = 13'sd0;
   localparam logic signed [ANG_W-1:0] RST_ANGLE_MAX = 13'sd2400;

   typedef enum logic [1:0] {
      KIND_POS   = 2'd0,
      KIND_ANGLE = 2'd1,
      KIND_STOP  = 2'd2,
      KIND_LOAD  = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SERVO_ID  = 3'd0,
      CSR_POS_MIN   = 3'd1,
      CSR_POS_MAX   = 3'd2,
      CSR_ANGLE_MIN = 3'd3,
      CSR_ANGLE_MAX = 3'd4
   } csr_index_type;

   typedef struct packed {
      kind_type          kind;
      logic [TIME_W-1:0] move_time;
      logic [POS_W-1:0]  pos_direct;
      logic              use_q;
   } meta_type;

   typedef struct packed {
      logic [ANG_W-1:0] r;
      logic [POS_W-1:0] w;
      logic [ANG_W-1:0] d;
   } div_type;

endpackage

// ----- rtl/bus_servo_command_framer_core.sv -----
// Top level of the bus servo command framer: position pipeline and byte serialiser.
//
// Usage:
//   req_*  carries one servo command per transaction (kind, target position,
//          target angle, move time). A transaction completes when req_valid is
//          high and req_stall is low.
//   rsp_*  carries the frame one byte per transaction; rsp_last_byte marks the
//          checksum byte. A move gives 10 bytes, stop 6, load 7.
//   csr_*  writes the id, position limits and angle limits; csr_ready is
//          always high. Write only while no command is in flight.
// Pipeline: 12 pipeline registers (limit clamp, two products, sum, eight divider
//   stages of two quotient bits each, position clamp) lead to the serialiser,
//   which registers the frame bytes in its own buffer.
// Throughput: the serialiser sends one byte per cycle while rsp_stall is low and
//   takes one command per frame; the pipeline takes a new command
//   in every cycle while the serialiser keeps up.
// Reset: synchronous; empties the pipeline and serialiser and loads the
//   register reset values (id 1, position 0..1000, angle 0..2400).
// A stall on rsp_stall holds the current byte; once the last pipeline stage
//   is full the whole pipeline holds and req_stall goes high.
module bus_servo_command_framer_core (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic [1:0]                                  req_kind,
   input  logic [bscf_pkg::POS_W-1:0]                  req_target_position,
   input  logic signed [bscf_pkg::ANG_W-1:0]           req_target_angle,
   input  logic [bscf_pkg::TIME_W-1:0]                 req_move_time_ms,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic [bscf_pkg::BYTE_W-1:0]                 rsp_frame_byte,
   output logic                                        rsp_last_byte,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [bscf_pkg::CSR_IDX_W-1:0]              csr_index,
   input  logic [bscf_pkg::CSR_DAT_W-1:0]              csr_wdata
);
   import bscf_pkg::*;

   localparam int unsigned NSTG = DIV_STG + 4;

   logic [BYTE_W-1:0]       servo_id_ff;
   logic [POS_W-1:0]        pos_min_ff;
   logic [POS_W-1:0]        pos_max_ff;
   logic signed [ANG_W-1:0] angle_min_ff;
   logic signed [ANG_W-1:0] angle_max_ff;

   logic [NSTG-1:0] v_ff;
   logic            adv;

   logic [ANG_W-1:0] s0_k_ff;
   logic [ANG_W-1:0] s0_dk_ff;
   logic [ANG_W-1:0] s0_d_ff;
   meta_type         s0_meta_ff;

   logic [PROD_W-1:0] s1_m1_ff;
   logic [PROD_W-1:0] s1_m2_ff;
   logic [ANG_W-1:0]  s1_d_ff;
   meta_type          s1_meta_ff;

   logic [NUM_W-1:0] s2_n_ff;
   logic [ANG_W-1:0] s2_d_ff;
   meta_type         s2_meta_ff;

   div_type  div_ff   [DIV_STG];
   meta_type div_meta_ff [DIV_STG];
   div_type  div_in   [DIV_STG];

   logic [POS_W-1:0]  f_pos_ff;
   kind_type          f_kind_ff;
   logic [TIME_W-1:0] f_time_ff;

   logic              ser_vld_ff;
   logic              ser_vld_in;
   logic [CNT_W-1:0]  ser_cnt_ff;
   logic [CNT_W-1:0]  ser_cnt_in;
   logic [BYTE_W-1:0] ser_buf_ff [FRAME_MAX];
   logic              ser_free;
   logic              ser_load;
   logic              ser_shift;

   logic [BYTE_W-1:0] fb [FRAME_MAX];
   logic [CNT_W-1:0]  fb_last;

   logic signed [ANG_W-1:0] ang_cl;
   logic signed [ANG_W:0]   d_w;
   logic signed [ANG_W:0]   k_w;
   logic signed [ANG_W:0]   dk_w;
   meta_type                s0_meta_in;

   logic [POS_W-1:0] q_sel;
   logic [POS_W-1:0] pos_cl;

   function automatic div_type div_step(div_type x);
      logic [ANG_W:0] t;
      logic           ge;
      div_type        y;
      t   = {x.r, x.w[POS_W-1]};
      ge  = (t >= {1'b0, x.d});
      y.d = x.d;
      y.r = ge ? ANG_W'(t - {1'b0, x.d}) : t[ANG_W-1:0];
      y.w = {x.w[POS_W-2:0], ge};
      return y;
   endfunction

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         servo_id_ff  <= RST_SERVO_ID;
         pos_min_ff   <= RST_POS_MIN;
         pos_max_ff   <= RST_POS_MAX;
         angle_min_ff <= RST_ANGLE_MIN;
         angle_max_ff <= RST_ANGLE_MAX;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_SERVO_ID:  servo_id_ff  <= csr_wdata[BYTE_W-1:0];
            CSR_POS_MIN:   pos_min_ff   <= csr_wdata[POS_W-1:0];
            CSR_POS_MAX:   pos_max_ff   <= csr_wdata[POS_W-1:0];
            CSR_ANGLE_MIN: angle_min_ff <= signed'(csr_wdata[ANG_W-1:0]);
            CSR_ANGLE_MAX: angle_max_ff <= signed'(csr_wdata[ANG_W-1:0]);
            default: ;
         endcase
      end
   end

   // pipeline control
   assign ser_free  = !ser_vld_ff || (!rsp_stall && (ser_cnt_ff == '0));
   assign adv       = !v_ff[NSTG-1] || ser_free;
   assign ser_load  = ser_free && v_ff[NSTG-1];
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NSTG-2:0], req_valid};
      end
   end

   // stage 0: angle clamp and map weights
   always_comb begin
      if (req_target_angle < angle_min_ff) begin
         ang_cl = angle_min_ff;
      end else if (req_target_angle > angle_max_ff) begin
         ang_cl = angle_max_ff;
      end else begin
         ang_cl = req_target_angle;
      end
      d_w  = {angle_max_ff[ANG_W-1], angle_max_ff} - {angle_min_ff[ANG_W-1], angle_min_ff};
      k_w  = {ang_cl[ANG_W-1], ang_cl} - {angle_min_ff[ANG_W-1], angle_min_ff};
      dk_w = {angle_max_ff[ANG_W-1], angle_max_ff} - {ang_cl[ANG_W-1], ang_cl};

      s0_meta_in.kind      = kind_type'(req_kind);
      s0_meta_in.move_time = req_move_time_ms;
      s0_meta_in.use_q     = (kind_type'(req_kind) == KIND_ANGLE) && !d_w[ANG_W] && (d_w != '0);
      if (kind_type'(req_kind) == KIND_POS) begin
         s0_meta_in.pos_direct = req_target_position;
      end else if (d_w[ANG_W] && (ang_cl != angle_min_ff)) begin
         s0_meta_in.pos_direct = pos_max_ff;
      end else begin
         s0_meta_in.pos_direct = pos_min_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_k_ff    <= k_w[ANG_W-1:0];
         s0_dk_ff   <= dk_w[ANG_W-1:0];
         s0_d_ff    <= d_w[ANG_W-1:0];
         s0_meta_ff <= s0_meta_in;
      end
   end

   // stage 1: weighted products; stage 2: numerator
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_m1_ff   <= PROD_W'(pos_min_ff) * PROD_W'(s0_dk_ff);
         s1_m2_ff   <= PROD_W'(pos_max_ff) * PROD_W'(s0_k_ff);
         s1_d_ff    <= s0_d_ff;
         s1_meta_ff <= s0_meta_ff;
         s2_n_ff    <= NUM_W'(s1_m1_ff) + NUM_W'(s1_m2_ff);
         s2_d_ff    <= s1_d_ff;
         s2_meta_ff <= s1_meta_ff;
      end
   end

   // divider stages, two quotient bits each
   always_comb begin
      div_in[0].r = s2_n_ff[POS_W+ANG_W-1:POS_W];
      div_in[0].w = s2_n_ff[POS_W-1:0];
      div_in[0].d = s2_d_ff;
      for (int i = 1; i < DIV_STG; i++) begin
         div_in[i] = div_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_meta_ff[0] <= s2_meta_ff;
         for (int i = 1; i < DIV_STG; i++) begin
            div_meta_ff[i] <= div_meta_ff[i-1];
         end
         for (int i = 0; i < DIV_STG; i++) begin
            div_ff[i] <= div_step(div_step(div_in[i]));
         end
      end
   end

   // final stage: position select and clamp
   always_comb begin
      q_sel = div_meta_ff[DIV_STG-1].use_q ? div_ff[DIV_STG-1].w
                                           : div_meta_ff[DIV_STG-1].pos_direct;
      if (q_sel < pos_min_ff) begin
         pos_cl = pos_min_ff;
      end else if (q_sel > pos_max_ff) begin
         pos_cl = pos_max_ff;
      end else begin
         pos_cl = q_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_pos_ff  <= pos_cl;
         f_kind_ff <= div_meta_ff[DIV_STG-1].kind;
         f_time_ff <= div_meta_ff[DIV_STG-1].move_time;
      end
   end

   // frame build
   always_comb begin
      for (int i = 0; i < FRAME_MAX; i++) begin
         fb[i] = '0;
      end
      fb[0] = HDR_BYTE;
      fb[1] = HDR_BYTE;
      fb[2] = servo_id_ff;
      case (f_kind_ff) inside
         KIND_POS, KIND_ANGLE: begin
            fb[3]   = LEN_MOVE;
            fb[4]   = CMD_MOVE;
            fb[5]   = f_pos_ff[BYTE_W-1:0];
            fb[6]   = f_pos_ff[POS_W-1:BYTE_W];
            fb[7]   = f_time_ff[BYTE_W-1:0];
            fb[8]   = f_time_ff[TIME_W-1:BYTE_W];
            fb[9]   = ~(fb[2] + fb[3] + fb[4] + fb[5] + fb[6] + fb[7] + fb[8]);
            fb_last = LAST_MOVE;
         end
         KIND_STOP: begin
            fb[3]   = LEN_STOP;
            fb[4]   = CMD_STOP;
            fb[5]   = ~(fb[2] + fb[3] + fb[4]);
            fb_last = LAST_STOP;
         end
         default: begin
            fb[3]   = LEN_LOAD;
            fb[4]   = CMD_LOAD;
            fb[5]   = LOAD_ARG;
            fb[6]   = ~(fb[2] + fb[3] + fb[4] + fb[5]);
            fb_last = LAST_LOAD;
         end
      endcase
   end

   // serialiser
   assign ser_shift = ser_vld_ff && !rsp_stall;

   always_comb begin
      ser_vld_in = ser_vld_ff;
      ser_cnt_in = ser_cnt_ff;
      if (ser_load) begin
         ser_vld_in = 1'b1;
         ser_cnt_in = fb_last;
      end else if (ser_free) begin
         ser_vld_in = 1'b0;
      end else if (ser_shift) begin
         ser_cnt_in = ser_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_vld_ff <= 1'b0;
         ser_cnt_ff <= '0;
      end else begin
         ser_vld_ff <= ser_vld_in;
         ser_cnt_ff <= ser_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_load) begin
         ser_buf_ff <= fb;
      end else if (ser_shift) begin
         for (int i = 0; i < FRAME_MAX - 1; i++) begin
            ser_buf_ff[i] <= ser_buf_ff[i+1];
         end
      end
   end

   assign rsp_valid      = ser_vld_ff;
   assign rsp_frame_byte = ser_buf_ff[0];
   assign rsp_last_byte  = (ser_cnt_ff == '0);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid && (v_ff == '0))
      else $error("framer not empty after reset");

   a_frame_header: assert property (@(posedge clock) disable iff (reset)
      ser_load |=> rsp_valid && (rsp_frame_byte == HDR_BYTE))
      else $error("frame does not open with header byte");

   a_frame_length: assert property (@(posedge clock) disable iff (reset)
      ser_load |=> (ser_cnt_ff == LAST_MOVE) || (ser_cnt_ff == LAST_STOP)
                   || (ser_cnt_ff == LAST_LOAD))
      else $error("frame length out of set");

   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_byte |=> rsp_valid)
      else $error("gap inside frame");

   a_tail_hold: assert property (@(posedge clock) disable iff (reset)
      v_ff[NSTG-1] && !adv |=> v_ff[NSTG-1] && $stable(f_pos_ff) && $stable(f_time_ff))
      else $error("held pipeline tail changed");

endmodule
